[hw/rtl/msdt_pkg.sv]
// Shared types and constants of the multi-slot deadline timer.
`default_nettype none

package msdt_pkg;

   // Table geometry
   localparam int SLOTS    = 64;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int TAG_BITS = 16;

   // Millisecond conversion
   localparam logic [31:0] FREQ_RESET = 32'd62500000;
   localparam int          MS_PER_S   = 1000;
   localparam int          REM_W      = 10;
   // x / 1000 equals (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
   localparam logic [28:0] RECIP_1000  = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;

   // Comparator delay ceiling
   localparam logic [63:0] MAX_TVAL = 64'h0000_0000_ffff_ffff;

   // Operation codes
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_CANCEL   = 2'd1;
   localparam logic [1:0] OP_EXPIRE   = 2'd2;

   // Status codes
   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_NO_HANDLER = 2'd1;
   localparam logic [1:0] STS_FULL       = 2'd2;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [63:0]         now;
      logic [31:0]         delay_ms;
      logic [TAG_BITS-1:0] tag;
      logic                handler_present;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                expired_valid;
      logic [TAG_BITS-1:0] expired_tag;
      logic [SLOT_W-1:0]   expired_slot;
      logic                last;
      logic                compare_enable;
      logic [31:0]         compare_delay;
      logic [63:0]         interrupt_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0]         deadline;
      logic [TAG_BITS-1:0] tag;
   } slot_entry_type;

endpackage

`default_nettype wire

[hw/rtl/multi_slot_deadline_timer.sv]
// Top level of the multi-slot deadline timer: slot table, sweeps and result output.
//
//   channel  | ports                         | moves
//   ---------+-------------------------------+-------------------------------------
//   request  | start, busy, req_word         | one word when start & !busy
//   result   | rsp_strobe, rsp_word          | one word per cycle with rsp_strobe
//   csr      | csr_valid, csr_ready, csr_data| counter_frequency when valid & ready
//
// Deadlines and tags sit in one single-port-read memory with a registered read;
// active marks sit in flip-flops. Every operation but cancel sweeps the table one
// slot per cycle through the memory read port. A schedule with a handler first
// does the millisecond conversion (reciprocal multiplications by 1/1000), and an
// expiry check that releases slots adds a second sweep that reads the released
// tags. No new request is taken until the last result word of the current one.
// Reset clears all marks and counters at once; no clearing pass is needed.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module multi_slot_deadline_timer
   import msdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_word,
   output logic             rsp_strobe,
   output rsp_type          rsp_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV1   = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_MUL2   = 4'd3;
   localparam logic [3:0] S_DIV2   = 4'd4;
   localparam logic [3:0] S_TICKS  = 4'd5;
   localparam logic [3:0] S_ADD    = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_REPORT = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // Control registers
   logic [3:0]        state_ff, state_in;
   logic [SLOTS-1:0]  active_ff, active_in;
   logic [63:0]       count_ff, count_in;
   logic [31:0]       freq_ff, freq_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              issue_run_ff, issue_run_in;

   // Operation and datapath registers
   logic [1:0]          op_ff, op_in;
   logic [63:0]         now_ff, now_in;
   logic [31:0]         ms_ff, ms_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                handler_ff, handler_in;
   logic [SLOTS-1:0]    exp_mask_ff, exp_mask_in;
   logic                exp_any_ff, exp_any_in;
   logic [SLOT_W-1:0]   last_exp_ff, last_exp_in;
   logic                found_ff, found_in;
   logic [63:0]         best_ff, best_in;
   logic                free_found_ff, free_found_in;
   logic [63:0]         newdl_ff, newdl_in;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         fq_ff, fq_in;
   logic [31:0]         mq_ff, mq_in;
   logic [REM_W-1:0]    frem_ff, frem_in;
   logic [REM_W-1:0]    mrem_ff, mrem_in;
   logic [19:0]         rm_ff, rm_in;
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0]   s1_idx_ff, s1_idx_in;
   logic                en_ff, en_in;
   logic [31:0]         dly_ff, dly_in;
   rsp_type             rsp_word_ff, rsp_word_in;

   // Slot memory
   slot_entry_type      slot_mem [SLOTS];
   slot_entry_type      rd_data_ff;
   logic                mem_we;

   // Datapath helpers
   logic                s1_act;
   logic                s1_ins;
   logic                s1_passed;
   logic [63:0]         s1_lag;
   logic                cand_v;
   logic [63:0]         cand_d;
   logic [63:0]         cand_gap;
   logic [63:0]         rep_diff;
   logic                rep_en;
   logic [31:0]         rep_dly;
   logic [1:0]          rep_status;

   // Divide a 32-bit value by 1000 through a reciprocal multiplication
   function automatic logic [31:0] div1000(input logic [31:0] x);
      logic [60:0] p;
      p = 61'(x) * 61'(RECIP_1000);
      return 32'(p[60:RECIP_SHIFT]);
   endfunction

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Sweep stage: slot data lines up with s1_idx_ff
   assign s1_act    = active_ff[s1_idx_ff];
   assign s1_ins    = (op_ff == OP_SCHEDULE) && handler_ff && !free_found_ff && !s1_act;
   assign s1_lag    = now_ff - rd_data_ff.deadline;
   assign s1_passed = (op_ff == OP_EXPIRE) && s1_act && !s1_lag[63];
   assign cand_v    = (s1_act && !s1_passed) || s1_ins;
   assign cand_d    = s1_ins ? newdl_ff : rd_data_ff.deadline;
   assign cand_gap  = cand_d - best_ff;

   // Comparator report from the earliest remaining deadline
   assign rep_diff = best_ff - now_ff;
   always_comb begin
      rep_en  = found_ff;
      rep_dly = 32'd0;
      if (found_ff) begin
         if (rep_diff == 64'd0 || rep_diff[63]) begin
            rep_dly = 32'd1;
         end else if (rep_diff > MAX_TVAL) begin
            rep_dly = MAX_TVAL[31:0];
         end else begin
            rep_dly = rep_diff[31:0];
         end
      end
      rep_status = STS_OK;
      if (op_ff == OP_SCHEDULE) begin
         if (!handler_ff) begin
            rep_status = STS_NO_HANDLER;
         end else if (!free_found_ff) begin
            rep_status = STS_FULL;
         end
      end
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      freq_in       = freq_ff;
      rsp_strobe_in = 1'b0;
      s1_valid_in   = 1'b0;
      issue_run_in  = issue_run_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      ms_in         = ms_ff;
      tag_in        = tag_ff;
      handler_in    = handler_ff;
      exp_mask_in   = exp_mask_ff;
      exp_any_in    = exp_any_ff;
      last_exp_in   = last_exp_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      free_found_in = free_found_ff;
      newdl_in      = newdl_ff;
      prod_in       = prod_ff;
      fq_in         = fq_ff;
      mq_in         = mq_ff;
      frem_in       = frem_ff;
      mrem_in       = mrem_ff;
      rm_in         = rm_ff;
      scan_idx_in   = scan_idx_ff;
      s1_idx_in     = s1_idx_ff;
      en_in         = en_ff;
      dly_in        = dly_ff;
      rsp_word_in   = rsp_word_ff;
      mem_we        = 1'b0;

      // take the frequency word
      if (csr_valid) begin
         freq_in = csr_data;
      end

      // issue one memory read per cycle during a sweep
      if ((state_ff == S_SCAN || state_ff == S_EMIT) && issue_run_ff) begin
         s1_valid_in = 1'b1;
         s1_idx_in   = scan_idx_ff;
         if (scan_idx_ff == LAST_SLOT) begin
            issue_run_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + SLOT_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = req_word.opcode;
               now_in        = req_word.now;
               ms_in         = req_word.delay_ms;
               tag_in        = req_word.tag;
               handler_in    = req_word.handler_present;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               exp_any_in    = 1'b0;
               exp_mask_in   = '0;
               scan_idx_in   = '0;
               issue_run_in  = 1'b1;
               case (req_word.opcode)
                  OP_CANCEL: begin
                     active_in = '0;
                     state_in  = S_REPORT;
                  end
                  OP_EXPIRE: begin
                     count_in = count_ff + 64'd1;
                     state_in = S_SCAN;
                  end
                  OP_SCHEDULE: begin
                     state_in = req_word.handler_present ? S_DIV1 : S_SCAN;
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_DIV1: begin
            // split frequency and delay into thousands
            fq_in    = div1000(freq_ff);
            mq_in    = div1000(ms_ff);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            // remainders by 1000 and the whole-kilohertz product
            frem_in  = REM_W'(freq_ff - fq_ff * 32'(MS_PER_S));
            mrem_in  = REM_W'(ms_ff - mq_ff * 32'(MS_PER_S));
            prod_in  = 64'(fq_ff) * 64'(ms_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            // rem * ms / 1000 = rem * (ms / 1000) + rem * (ms % 1000) / 1000
            prod_in  = prod_ff + 64'(frem_ff) * 64'(mq_ff);
            rm_in    = 20'(frem_ff) * 20'(mrem_ff);
            state_in = S_DIV2;
         end
         S_DIV2: begin
            prod_in  = prod_ff + 64'(div1000(32'(rm_ff)));
            state_in = S_TICKS;
         end
         S_TICKS: begin
            // at least one tick
            prod_in  = (prod_ff == 64'd0) ? 64'd1 : prod_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            newdl_in = now_ff + prod_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (s1_valid_ff) begin
               // insert into the lowest free slot
               if (s1_ins) begin
                  free_found_in         = 1'b1;
                  active_in[s1_idx_ff]  = 1'b1;
                  mem_we                = 1'b1;
               end
               // release a passed deadline
               if (s1_passed) begin
                  active_in[s1_idx_ff]   = 1'b0;
                  exp_mask_in[s1_idx_ff] = 1'b1;
                  exp_any_in             = 1'b1;
                  last_exp_in            = s1_idx_ff;
               end
               // track the earliest remaining deadline
               if (cand_v && (!found_ff || cand_gap[63])) begin
                  best_in  = cand_d;
                  found_in = 1'b1;
               end
               if (s1_idx_ff == LAST_SLOT) begin
                  state_in = S_REPORT;
               end
            end
         end
         S_REPORT: begin
            en_in  = rep_en;
            dly_in = rep_dly;
            if (op_ff == OP_EXPIRE && exp_any_ff) begin
               scan_idx_in  = '0;
               issue_run_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               rsp_strobe_in               = 1'b1;
               rsp_word_in.status          = rep_status;
               rsp_word_in.expired_valid   = 1'b0;
               rsp_word_in.expired_tag     = '0;
               rsp_word_in.expired_slot    = '0;
               rsp_word_in.last            = 1'b1;
               rsp_word_in.compare_enable  = rep_en;
               rsp_word_in.compare_delay   = rep_dly;
               rsp_word_in.interrupt_count = count_ff;
               state_in                    = S_IDLE;
            end
         end
         S_EMIT: begin
            if (s1_valid_ff) begin
               // emit one word per released slot
               if (exp_mask_ff[s1_idx_ff]) begin
                  rsp_strobe_in               = 1'b1;
                  rsp_word_in.status          = STS_OK;
                  rsp_word_in.expired_valid   = 1'b1;
                  rsp_word_in.expired_tag     = rd_data_ff.tag;
                  rsp_word_in.expired_slot    = s1_idx_ff;
                  rsp_word_in.last            = (s1_idx_ff == last_exp_ff);
                  rsp_word_in.compare_enable  = en_ff;
                  rsp_word_in.compare_delay   = dly_ff;
                  rsp_word_in.interrupt_count = count_ff;
               end
               if (s1_idx_ff == LAST_SLOT) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         count_ff      <= '0;
         freq_ff       <= FREQ_RESET;
         rsp_strobe_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         issue_run_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         freq_ff       <= freq_in;
         rsp_strobe_ff <= rsp_strobe_in;
         s1_valid_ff   <= s1_valid_in;
         issue_run_ff  <= issue_run_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      ms_ff         <= ms_in;
      tag_ff        <= tag_in;
      handler_ff    <= handler_in;
      exp_mask_ff   <= exp_mask_in;
      exp_any_ff    <= exp_any_in;
      last_exp_ff   <= last_exp_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      free_found_ff <= free_found_in;
      newdl_ff      <= newdl_in;
      prod_ff       <= prod_in;
      fq_ff         <= fq_in;
      mq_ff         <= mq_in;
      frem_ff       <= frem_in;
      mrem_ff       <= mrem_in;
      rm_ff         <= rm_in;
      scan_idx_ff   <= scan_idx_in;
      s1_idx_ff     <= s1_idx_in;
      en_ff         <= en_in;
      dly_ff        <= dly_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Slot memory: write the new slot, read the next slot of the sweep
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[s1_idx_ff] <= '{deadline: newdl_ff, tag: tag_ff};
      end
      rd_data_ff <= slot_mem[scan_idx_ff];
   end

endmodule

`default_nettype wire
